// ----- rtl/bml_traffic_grid_step_defines.svh -----
// assertion macros for the traffic grid block
// expects clk_i and rst_ni in the including module
`ifndef BML_TRAFFIC_GRID_STEP_DEFINES_SVH
`define BML_TRAFFIC_GRID_STEP_DEFINES_SVH

// same-cycle implication
`define BML_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BML_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// delayed implication
`define BML_ASSERT_DLY2(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

// ----- rtl/bml_pkg.sv -----
// shared types, codes and the cell move rule of the traffic grid block
// no dependencies
package bml_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_RED,
    ST_RED_DRAIN,
    ST_BLUE,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    FN_WRITE = 2'd0,
    FN_READ  = 2'd1,
    FN_STEP  = 2'd2
  } func_e;

  localparam logic [1:0] CELL_EMPTY = 2'd0;
  localparam logic [1:0] CELL_RED   = 2'd1;
  localparam logic [1:0] CELL_BLUE  = 2'd2;

  localparam logic [0:0] CFG_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic valid;
    logic blue;
    logic save_first;
    logic write;
    logic use_first;
    logic last;
  } issue_t;

  function automatic logic [1:0] next_cell(logic [1:0] mover, logic [1:0] left,
                                           logic [1:0] mid, logic [1:0] right);
    logic [1:0] res;
    res = mid;
    if (mid == mover && right == CELL_EMPTY) begin
      res = CELL_EMPTY;
    end else if (mid == CELL_EMPTY && left == mover) begin
      res = mover;
    end
    return res;
  endfunction

endpackage

// ----- rtl/bml_traffic_grid_step.sv -----
// traffic automaton on a toroidal grid: cell store, step sequencer and window chain
// depends on bml_pkg, bml_ram, bml_cell, bml_sweep and the defines header
//
// usage: drive func_i, row_i, col_i, cell_in_i with start_i; the word is taken at
// a rising edge where start_i is high and busy_o is low. every word gives one
// result word on cell_out_o and out_of_range_o, shown for one cycle with done_o.
// the receiver cannot stall; results are never held back.
// a write or a no-op answers in the next cycle and busy_o stays low, so one such
// word can be taken every cycle. a read answers after the registered ram read and
// the registered result word, and holds busy_o for one cycle.
// a step walks the grid one cell per cycle through the ram port and a two-cell
// window chain: the red phase sweeps every row, then a drain state, then the blue
// phase sweeps every column, then a finish state; busy_o is high throughout and
// done_o follows. size registers are written on cfg_we_i; the user must write
// them only while the block is idle, which the block itself does not enforce.
// after reset the grid is cleared one cell per cycle, 2**(clog2(MAX_HEIGHT)+
// clog2(MAX_WIDTH)) cells (4096 by default), while busy_o stays high.
module bml_traffic_grid_step #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] func_i,
  input  logic [5:0] row_i,
  input  logic [5:0] col_i,
  input  logic [1:0] cell_in_i,
  output logic       done_o,
  output logic [1:0] cell_out_o,
  output logic       out_of_range_o,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [6:0] cfg_data_i
);

  `include "bml_traffic_grid_step_defines.svh"

  localparam int unsigned CB = $clog2(MAX_WIDTH);
  localparam int unsigned RB = $clog2(MAX_HEIGHT);
  localparam int unsigned DB = (CB > RB) ? CB : RB;
  localparam int unsigned AB = RB + CB;
  localparam int unsigned VW = ((DB + 1) > 7) ? DB + 1 : 7;

  bml_pkg::state_e state_q, state_d;

  logic [6:0]    width_q, height_q;
  logic [DB:0]   wu, hu;
  logic [AB-1:0] clr_q, clr_d;

  logic          accept;
  logic          in_oor;
  logic [AB-1:0] in_addr;
  logic [1:0]    in_val;
  logic          rd_oor_q;

  logic          done_q, done_d;
  logic [1:0]    cell_out_q, cell_out_d;
  logic          oor_q, oor_d;

  logic          clearing;
  logic          sweep_run;
  logic          sweep_blue;

  bml_pkg::issue_t issue, tag_q;
  logic [AB-1:0]   sweep_addr, tag_addr_q;

  logic          ram_we;
  logic [AB-1:0] ram_waddr, ram_raddr;
  logic [1:0]    ram_wdata, ram_rdata;

  logic [1:0]    first_q;
  logic [1:0]    right_val;
  logic [1:0]    mover;
  logic [1:0]    c0_val, c1_val;
  logic [AB-1:0] c0_addr, c1_addr;

  logic          in_step;
  logic          phase_end;
  logic          same_line;

  // sizes in use, saturated to 2..max
  always_comb begin
    if (VW'(width_q) < VW'(2)) begin
      wu = (DB+1)'(2);
    end else if (VW'(width_q) > VW'(MAX_WIDTH)) begin
      wu = (DB+1)'(MAX_WIDTH);
    end else begin
      wu = (DB+1)'(width_q);
    end
    if (VW'(height_q) < VW'(2)) begin
      hu = (DB+1)'(2);
    end else if (VW'(height_q) > VW'(MAX_HEIGHT)) begin
      hu = (DB+1)'(MAX_HEIGHT);
    end else begin
      hu = (DB+1)'(height_q);
    end
  end

  assign accept  = start_i && !busy_o;
  assign in_oor  = (VW'(row_i) >= VW'(hu)) || (VW'(col_i) >= VW'(wu));
  assign in_addr = {RB'(row_i), CB'(col_i)};
  assign in_val  = (cell_in_i == bml_pkg::CELL_RED || cell_in_i == bml_pkg::CELL_BLUE)
                   ? cell_in_i : bml_pkg::CELL_EMPTY;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bml_pkg::ST_CLEAR: begin
        if (&clr_q) state_d = bml_pkg::ST_IDLE;
      end
      bml_pkg::ST_IDLE: begin
        if (accept) begin
          case (func_i)
            bml_pkg::FN_READ: state_d = bml_pkg::ST_READ;
            bml_pkg::FN_STEP: state_d = bml_pkg::ST_RED;
            default:          state_d = bml_pkg::ST_IDLE;
          endcase
        end
      end
      bml_pkg::ST_READ:      state_d = bml_pkg::ST_IDLE;
      bml_pkg::ST_RED: begin
        if (issue.last) state_d = bml_pkg::ST_RED_DRAIN;
      end
      bml_pkg::ST_RED_DRAIN: state_d = bml_pkg::ST_BLUE;
      bml_pkg::ST_BLUE: begin
        if (issue.last) state_d = bml_pkg::ST_FINISH;
      end
      bml_pkg::ST_FINISH:    state_d = bml_pkg::ST_IDLE;
      default:               state_d = bml_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy_o     = 1'b1;
    clearing   = 1'b0;
    sweep_run  = 1'b0;
    sweep_blue = 1'b0;
    case (state_q)
      bml_pkg::ST_CLEAR: clearing = 1'b1;
      bml_pkg::ST_IDLE:  busy_o = 1'b0;
      bml_pkg::ST_RED:   sweep_run = 1'b1;
      bml_pkg::ST_BLUE: begin
        sweep_run  = 1'b1;
        sweep_blue = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

  assign clr_d = clearing ? clr_q + AB'(1) : clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bml_pkg::ST_CLEAR;
      clr_q    <= '0;
      width_q  <= 7'd60;
      height_q <= 7'd40;
      rd_oor_q <= 1'b0;
      done_q   <= 1'b0;
      tag_q    <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
      tag_q   <= issue;
      if (accept) begin
        rd_oor_q <= in_oor;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bml_pkg::CFG_WIDTH:  width_q  <= cfg_data_i;
          bml_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // result word
  always_comb begin
    done_d     = 1'b0;
    cell_out_d = bml_pkg::CELL_EMPTY;
    oor_d      = 1'b0;
    case (state_q)
      bml_pkg::ST_IDLE: begin
        if (accept) begin
          case (func_i)
            bml_pkg::FN_WRITE: begin
              done_d = 1'b1;
              oor_d  = in_oor;
            end
            bml_pkg::FN_READ: done_d = 1'b0;
            bml_pkg::FN_STEP: done_d = 1'b0;
            default:          done_d = 1'b1;
          endcase
        end
      end
      bml_pkg::ST_READ: begin
        done_d     = 1'b1;
        oor_d      = rd_oor_q;
        cell_out_d = rd_oor_q ? bml_pkg::CELL_EMPTY : ram_rdata;
      end
      bml_pkg::ST_FINISH: done_d = 1'b1;
      default:            done_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cell_out_q <= cell_out_d;
    oor_q      <= oor_d;
  end

  assign done_o         = done_q;
  assign cell_out_o     = cell_out_q;
  assign out_of_range_o = oor_q;

  bml_sweep #(
    .RB(RB),
    .CB(CB),
    .DB(DB)
  ) u_sweep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .run_i   (sweep_run),
    .blue_i  (sweep_blue),
    .wu_i    (wu),
    .hu_i    (hu),
    .issue_o (issue),
    .addr_o  (sweep_addr)
  );

  // tag stage lines up with the registered ram read
  always_ff @(posedge clk_i) begin
    tag_addr_q <= sweep_addr;
    if (tag_q.valid && tag_q.save_first) begin
      first_q <= ram_rdata;
    end
  end

  assign right_val = tag_q.use_first ? first_q : ram_rdata;
  assign mover     = tag_q.blue ? bml_pkg::CELL_BLUE : bml_pkg::CELL_RED;

  bml_cell #(.AW(AB)) u_cell0 (
    .clk_i   (clk_i),
    .shift_i (tag_q.valid),
    .val_i   (right_val),
    .addr_i  (tag_addr_q),
    .val_o   (c0_val),
    .addr_o  (c0_addr)
  );

  bml_cell #(.AW(AB)) u_cell1 (
    .clk_i   (clk_i),
    .shift_i (tag_q.valid),
    .val_i   (c0_val),
    .addr_i  (c0_addr),
    .val_o   (c1_val),
    .addr_o  (c1_addr)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = in_addr;
    ram_wdata = in_val;
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = bml_pkg::CELL_EMPTY;
    end else if (tag_q.valid && tag_q.write) begin
      ram_we    = 1'b1;
      ram_waddr = c0_addr;
      ram_wdata = bml_pkg::next_cell(mover, c1_val, c0_val, right_val);
    end else if (state_q == bml_pkg::ST_IDLE && accept &&
                 func_i == bml_pkg::FN_WRITE && !in_oor) begin
      ram_we = 1'b1;
    end
  end

  assign ram_raddr = (state_q == bml_pkg::ST_IDLE) ? in_addr : sweep_addr;

  bml_ram #(
    .WIDTH(2),
    .DEPTH(2 ** AB)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_step   = state_q == bml_pkg::ST_RED || state_q == bml_pkg::ST_RED_DRAIN ||
                     state_q == bml_pkg::ST_BLUE || state_q == bml_pkg::ST_FINISH;
  assign phase_end = state_q == bml_pkg::ST_RED_DRAIN || state_q == bml_pkg::ST_FINISH;
  assign same_line = tag_q.blue ? (c1_addr[CB-1:0] == c0_addr[CB-1:0])
                                : (c1_addr[AB-1:CB] == c0_addr[AB-1:CB]);

  `BML_ASSERT_NXT(a_step_goes_busy, accept && func_i == bml_pkg::FN_STEP, busy_o, "step not busy")
  `BML_ASSERT_DLY2(a_read_answers, accept && func_i == bml_pkg::FN_READ, done_o, "read lost")
  `BML_ASSERT_IMP(a_tag_in_step, tag_q.valid, in_step, "window write outside step")
  `BML_ASSERT_IMP(a_last_ends_phase, tag_q.valid && tag_q.last, phase_end, "phase end misplaced")
  `BML_ASSERT_IMP(a_window_line, tag_q.valid && tag_q.write, same_line, "window spans two lines")
  `BML_ASSERT_IMP(a_quiet_clear, state_q == bml_pkg::ST_CLEAR, !done_o && !tag_q.valid, "activity during clear")

endmodule

// ----- rtl/bml_ram.sv -----
// generic single write, single read ram with registered read data
// no dependencies
module bml_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/bml_cell.sv -----
// one stage of the snapshot window chain: a cell value and its grid address
// no dependencies
module bml_cell #(
  parameter int unsigned AW = 12
) (
  input  logic          clk_i,
  input  logic          shift_i,
  input  logic [1:0]    val_i,
  input  logic [AW-1:0] addr_i,
  output logic [1:0]    val_o,
  output logic [AW-1:0] addr_o
);

  logic [1:0]    val_q;
  logic [AW-1:0] addr_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      val_q  <= val_i;
      addr_q <= addr_i;
    end
  end

  assign val_o  = val_q;
  assign addr_o = addr_q;

endmodule

// ----- rtl/bml_sweep.sv -----
// line and slot counters that walk the grid for one phase of a step
// depends on bml_pkg
module bml_sweep #(
  parameter int unsigned RB = 6,
  parameter int unsigned CB = 6,
  parameter int unsigned DB = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              run_i,
  input  logic              blue_i,
  input  logic [DB:0]       wu_i,
  input  logic [DB:0]       hu_i,
  output bml_pkg::issue_t   issue_o,
  output logic [RB+CB-1:0]  addr_o
);

  logic [DB-1:0] line_q, line_d;
  logic [DB:0]   slot_q, slot_d;
  logic [DB:0]   len;
  logic [DB:0]   nlines;
  logic [DB:0]   pos;
  logic          use_first;
  logic          last_line;

  assign len       = blue_i ? hu_i : wu_i;
  assign nlines    = blue_i ? wu_i : hu_i;
  assign use_first = (slot_q == len + (DB+1)'(1));
  assign last_line = ({1'b0, line_q} == nlines - (DB+1)'(1));
  assign pos       = (slot_q == '0) ? len - (DB+1)'(1) : slot_q - (DB+1)'(1);

  always_comb begin
    line_d = line_q;
    slot_d = slot_q + (DB+1)'(1);
    if (!run_i) begin
      line_d = '0;
      slot_d = '0;
    end else if (use_first) begin
      slot_d = '0;
      line_d = last_line ? '0 : line_q + DB'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0;
      slot_q <= '0;
    end else begin
      line_q <= line_d;
      slot_q <= slot_d;
    end
  end

  always_comb begin
    issue_o.valid      = run_i;
    issue_o.blue       = blue_i;
    issue_o.save_first = (slot_q == (DB+1)'(1));
    issue_o.write      = (slot_q >= (DB+1)'(2));
    issue_o.use_first  = use_first;
    issue_o.last       = use_first && last_line;
  end

  assign addr_o = blue_i ? {RB'(pos), CB'(line_q)} : {RB'(line_q), CB'(pos)};

endmodule

// ----- test/bml_grid_checker.sv -----
// checker for the traffic grid block: keeps its own copy of the grid and the size
// registers, predicts each result word and compares it with what the block returns
// depends on bml_pkg
module bml_grid_checker #(
  parameter int GRID_W = 64,
  parameter int GRID_H = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       busy_i,
  input  logic [1:0] func_i,
  input  logic [5:0] row_i,
  input  logic [5:0] col_i,
  input  logic [1:0] cell_in_i,
  input  logic       done_i,
  input  logic [1:0] cell_out_i,
  input  logic       out_of_range_i,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [6:0] cfg_data_i,
  output int         fail_cnt_o,
  output int         pending_o,
  output int         checked_o
);
  import bml_pkg::*;

  typedef struct packed {
    logic [1:0] cell_out;
    logic       oor;
  } answer_t;

  answer_t    answer_q[$];
  answer_t    want;
  logic [1:0] cells [GRID_H][GRID_W];
  logic [1:0] snap  [GRID_H][GRID_W];
  logic [6:0] width_reg;
  logic [6:0] height_reg;
  int         span_w;
  int         span_h;

  function automatic int fit_span(logic [6:0] v, int lim);
    if (v < 2) return 2;
    if (v > lim) return lim;
    return int'(v);
  endfunction

  task automatic take_snapshot();
    for (int r = 0; r < GRID_H; r++) begin
      for (int c = 0; c < GRID_W; c++) begin
        snap[r][c] = cells[r][c];
      end
    end
  endtask

  // red cars shift right, then blue cars shift down against the updated grid
  task automatic advance_grid(input int w, input int h);
    int nxt;
    take_snapshot();
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        nxt = (c + 1) % w;
        if (snap[r][c] == CELL_RED && snap[r][nxt] == CELL_EMPTY) begin
          cells[r][nxt] = CELL_RED;
          cells[r][c]   = CELL_EMPTY;
        end
      end
    end
    take_snapshot();
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        nxt = (r + 1) % h;
        if (snap[r][c] == CELL_BLUE && snap[nxt][c] == CELL_EMPTY) begin
          cells[nxt][c] = CELL_BLUE;
          cells[r][c]   = CELL_EMPTY;
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < GRID_H; r++) begin
        for (int c = 0; c < GRID_W; c++) begin
          cells[r][c] = CELL_EMPTY;
        end
      end
      width_reg  = 7'd60;
      height_reg = 7'd40;
      answer_q.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
      checked_o  = 0;
    end else begin
      if (done_i) begin
        if (answer_q.size() == 0) begin
          $error("result word with none expected: cell_out %0d out_of_range %0d",
                 cell_out_i, out_of_range_i);
          fail_cnt_o++;
        end else begin
          want = answer_q.pop_front();
          checked_o++;
          if (cell_out_i !== want.cell_out) begin
            $error("cell_out: expected %0d, got %0d", want.cell_out, cell_out_i);
            fail_cnt_o++;
          end
          if (out_of_range_i !== want.oor) begin
            $error("out_of_range: expected %0d, got %0d", want.oor, out_of_range_i);
            fail_cnt_o++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_WIDTH) begin
          width_reg = cfg_data_i;
        end else begin
          height_reg = cfg_data_i;
        end
      end
      if (start_i && !busy_i) begin
        want   = '0;
        span_w = fit_span(width_reg, GRID_W);
        span_h = fit_span(height_reg, GRID_H);
        case (func_i)
          FN_WRITE, FN_READ: begin
            if (row_i >= span_h || col_i >= span_w) begin
              want.oor = 1'b1;
            end else if (func_i == FN_WRITE) begin
              // only red and blue are stored, anything else clears the cell
              cells[row_i][col_i] = (cell_in_i == CELL_RED || cell_in_i == CELL_BLUE) ?
                                    cell_in_i : CELL_EMPTY;
            end else begin
              want.cell_out = cells[row_i][col_i];
            end
          end
          FN_STEP: begin
            advance_grid(span_w, span_h);
          end
          default: begin
          end
        endcase
        answer_q.push_back(want);
      end
      pending_o = answer_q.size();
    end
  end

endmodule

// ----- test/bml_traffic_grid_step_tb.sv -----
// testbench top for bml_traffic_grid_step: directed words, then random phases over
// several grid sizes with random idle gaps; checking is done by bml_grid_checker
// depends on bml_pkg, bml_grid_checker and the block itself
module bml_traffic_grid_step_tb;
  import bml_pkg::*;

  localparam logic [1:0] FN_NOP    = 2'd3;
  localparam logic [1:0] CELL_VOID = 2'd3;
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 13;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] func;
  logic [5:0] row;
  logic [5:0] col;
  logic [1:0] cell_in;
  logic       done;
  logic [1:0] cell_out;
  logic       oor;
  logic       cfg_we;
  logic [0:0] cfg_idx;
  logic [6:0] cfg_data;

  int fail_cnt;
  int pending;
  int checked;
  int n_writes;
  int n_reads;
  int n_steps;
  int n_nops;
  int n_sizes;
  int span_w;
  int span_h;
  int waited;
  bit quiet;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  bml_traffic_grid_step dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_o         (busy),
    .func_i         (func),
    .row_i          (row),
    .col_i          (col),
    .cell_in_i      (cell_in),
    .done_o         (done),
    .cell_out_o     (cell_out),
    .out_of_range_o (oor),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data)
  );

  bml_grid_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .func_i         (func),
    .row_i          (row),
    .col_i          (col),
    .cell_in_i      (cell_in),
    .done_i         (done),
    .cell_out_i     (cell_out),
    .out_of_range_i (oor),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .fail_cnt_o     (fail_cnt),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  function automatic int clamp_span(logic [6:0] v);
    if (v < 2) return 2;
    if (v > 64) return 64;
    return int'(v);
  endfunction

  function automatic logic [6:0] draw_span();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 7'($urandom_range(0, 2));
    if (k == 1) return 7'($urandom_range(0, 127));
    return 7'($urandom_range(2, 12));
  endfunction

  task automatic send_word(input logic [1:0] f, input logic [5:0] r, input logic [5:0] c,
                           input logic [1:0] v);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 18);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    func    <= f;
    row     <= r;
    col     <= c;
    cell_in <= v;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (f)
      FN_WRITE: n_writes++;
      FN_READ:  n_reads++;
      FN_STEP:  n_steps++;
      default:  n_nops++;
    endcase
  endtask

  // sizes change only once the block is idle and every result is in
  task automatic write_sizes(input logic [6:0] wv, input logic [6:0] hv);
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_WIDTH;
    cfg_data <= wv;
    @(negedge clk);
    cfg_idx  <= CFG_HEIGHT;
    cfg_data <= hv;
    @(negedge clk);
    cfg_we <= 1'b0;
    span_w = clamp_span(wv);
    span_h = clamp_span(hv);
    n_sizes++;
  endtask

  task automatic random_word();
    int         k;
    int         step_pct;
    logic [5:0] r;
    logic [5:0] c;
    logic [1:0] v;
    k        = $urandom_range(0, 99);
    step_pct = (span_w * span_h > 1024) ? 4 : 15;
    v        = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 99) < 85) begin
      r = 6'($urandom_range(0, span_h - 1));
      c = 6'($urandom_range(0, span_w - 1));
    end else begin
      r = 6'($urandom_range(0, 63));
      c = 6'($urandom_range(0, 63));
    end
    if (k < 5) begin
      send_word(FN_NOP, r, c, v);
    end else if (k < 5 + step_pct) begin
      send_word(FN_STEP, r, c, v);
    end else if (k < 55) begin
      send_word(FN_WRITE, r, c, v);
    end else begin
      send_word(FN_READ, r, c, v);
    end
  endtask

  initial begin
    #50_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n    = 1'b0;
    start    = 1'b0;
    func     = FN_WRITE;
    row      = '0;
    col      = '0;
    cell_in  = CELL_EMPTY;
    cfg_we   = 1'b0;
    cfg_idx  = CFG_WIDTH;
    cfg_data = '0;
    n_writes = 0;
    n_reads  = 0;
    n_steps  = 0;
    n_nops   = 0;
    n_sizes  = 1;
    span_w   = 60;
    span_h   = 40;
    quiet    = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset sizes, corners and coordinates past the edge
    send_word(FN_READ, 6'd0, 6'd0, CELL_EMPTY);
    send_word(FN_WRITE, 6'd39, 6'd59, CELL_BLUE);
    send_word(FN_READ, 6'd39, 6'd59, CELL_EMPTY);
    send_word(FN_WRITE, 6'd40, 6'd0, CELL_RED);
    send_word(FN_READ, 6'd0, 6'd60, CELL_EMPTY);
    send_word(FN_READ, 6'd63, 6'd63, CELL_VOID);
    send_word(FN_STEP, 6'd63, 6'd63, CELL_VOID);
    send_word(FN_READ, 6'd0, 6'd59, CELL_EMPTY);

    // 3 by 3: red wrap blocked, blue blocked by a red that just moved in
    write_sizes(7'd3, 7'd3);
    send_word(FN_WRITE, 6'd0, 6'd0, CELL_RED);
    send_word(FN_WRITE, 6'd0, 6'd2, CELL_RED);
    send_word(FN_WRITE, 6'd2, 6'd1, CELL_BLUE);
    send_word(FN_WRITE, 6'd1, 6'd1, CELL_BLUE);
    send_word(FN_WRITE, 6'd1, 6'd2, CELL_VOID);
    send_word(FN_READ, 6'd1, 6'd2, CELL_EMPTY);
    send_word(FN_STEP, 6'd0, 6'd0, CELL_EMPTY);
    send_word(FN_READ, 6'd0, 6'd0, CELL_EMPTY);
    send_word(FN_READ, 6'd0, 6'd1, CELL_EMPTY);
    send_word(FN_READ, 6'd0, 6'd2, CELL_EMPTY);
    send_word(FN_READ, 6'd1, 6'd1, CELL_EMPTY);
    send_word(FN_READ, 6'd2, 6'd1, CELL_EMPTY);
    send_word(FN_NOP, 6'h3f, 6'h3f, CELL_VOID);
    send_word(FN_WRITE, 6'd0, 6'd3, CELL_RED);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       write_sizes(7'd0, 7'd1);
        1:       write_sizes(7'd127, 7'd64);
        default: write_sizes(draw_span(), draw_span());
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      repeat (PHASE_WORDS) random_word();
    end

    @(negedge clk);
    start  <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (20) @(negedge clk);
    if (pending != 0) begin
      $error("%0d result words never arrived", pending);
    end

    $display("sent %0d writes, %0d reads, %0d steps and %0d no-ops over %0d grid sizes",
             n_writes, n_reads, n_steps, n_nops, n_sizes);
    $display("%0d result words checked, %0d mismatches", checked, fail_cnt);
    if (fail_cnt == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
